// ===== rtl/fts_pkg.sv =====
// Types, op codes and register constants for the frame timestamp normaliser.
`default_nettype none
package fts_pkg;

  localparam int unsigned TicksPerSecond = 10000000;
  localparam int unsigned ResetFrameRate = 30;

  localparam int unsigned NOM_W  = 24;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned MT_W   = 63;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [NOM_W-1:0] NOMINAL_RESET = NOM_W'(TicksPerSecond / ResetFrameRate);

  // op codes
  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_NOMINAL = 1'b0;

  typedef struct packed {
    logic [1:0]      op;
    logic [TS_W-1:0] timestamp;
    logic [TS_W-1:0] window_limit;
  } item_t;

  typedef struct packed {
    logic             anchor_valid;
    logic [MT_W-1:0]  anchor_time;
    logic [MT_W-1:0]  last_media_time;
    logic [MT_W-1:0]  last_ts;          // anchor_time + last_media_time
    logic [CNT_W-1:0] submit_count;
    logic [CNT_W-1:0] drop_count;
  } state_t;

  typedef struct packed {
    logic             accepted;
    logic [MT_W-1:0]  media_time;
    logic [MT_W-1:0]  duration;
    logic [CNT_W-1:0] submitted_total;
    logic [CNT_W-1:0] dropped_total;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/fts_step.sv =====
// Single-pass step logic: result and next timeline state for one beat.
`default_nettype none
module fts_step import fts_pkg::*; (
  input  item_t            item_i,
  input  state_t           state_i,
  input  logic [NOM_W-1:0] nominal_i,
  output state_t           state_o,
  output result_t          result_o
);

  logic [NOM_W-1:0] nominal_eff;
  logic [TS_W-1:0]  cand;
  logic [MT_W-1:0]  gap;
  logic [TS_W-1:0]  fin_dur;
  logic             too_early;
  logic             over_limit;
  logic             fin_ok;

  assign nominal_eff = (nominal_i == '0) ? NOM_W'(1) : nominal_i;

  // Last kept frame's capture time is held directly, so the ordering check
  // is a plain compare against the timestamp.
  assign too_early  = {1'b0, item_i.timestamp[MT_W-1:0]} <= {1'b0, state_i.last_ts};
  assign cand       = {1'b0, item_i.timestamp[MT_W-1:0]} - {1'b0, state_i.anchor_time};
  assign over_limit = !item_i.window_limit[TS_W-1] &&
                      ($signed(cand) >= $signed(item_i.window_limit));
  assign gap        = item_i.timestamp[MT_W-1:0] - state_i.last_ts;

  assign fin_ok  = $signed(item_i.timestamp) > $signed({1'b0, state_i.last_media_time});
  assign fin_dur = item_i.timestamp - {1'b0, state_i.last_media_time};

  always_comb begin
    logic drop;
    drop     = 1'b0;
    state_o  = state_i;
    result_o = '0;
    case (item_i.op)
      OP_SUBMIT: begin
        state_o.submit_count = state_i.submit_count + CNT_W'(1);
        if (item_i.timestamp[TS_W-1]) begin
          drop = 1'b1;
        end else if (!state_i.anchor_valid) begin
          if (item_i.window_limit == '0) begin
            drop = 1'b1;
          end else begin
            state_o.anchor_valid    = 1'b1;
            state_o.anchor_time     = item_i.timestamp[MT_W-1:0];
            state_o.last_media_time = '0;
            state_o.last_ts         = item_i.timestamp[MT_W-1:0];
            result_o.accepted       = 1'b1;
            result_o.duration       = MT_W'(nominal_eff);
          end
        end else if (too_early || over_limit) begin
          drop = 1'b1;
        end else begin
          state_o.last_media_time = cand[MT_W-1:0];
          state_o.last_ts         = item_i.timestamp[MT_W-1:0];
          result_o.accepted       = 1'b1;
          result_o.media_time     = cand[MT_W-1:0];
          result_o.duration       = gap;
        end
      end
      OP_FINALIZE: begin
        if (state_i.anchor_valid && fin_ok) begin
          result_o.accepted   = 1'b1;
          result_o.media_time = state_i.last_media_time;
          result_o.duration   = fin_dur[MT_W-1:0];
        end
      end
      OP_CLEAR: begin
        state_o = '0;
      end
      default: begin
      end
    endcase
    if (drop) begin
      state_o.drop_count = state_i.drop_count + CNT_W'(1);
    end
    result_o.submitted_total = state_o.submit_count;
    result_o.dropped_total   = state_o.drop_count;
  end

endmodule
`default_nettype wire

// ===== rtl/frame_timestamp_normalizer.sv =====
// Top level: input register, timeline state, result register and APB register port.
//
//  channel | dir    | handshake             | payload
//  --------+--------+-----------------------+-----------------------------------------
//  in      | sink   | in_valid_i/in_ready_o | op_i, timestamp_i, window_limit_i
//  out     | source | out_valid_o/out_ready_i | accepted_o, media_time_o, duration_o,
//          |        |                       | submitted_total_o, dropped_total_o
//  apb     | slave  | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// One beat per cycle sustained while the output is not blocked; a taken beat passes from
// the input register through the step logic into the result register, from which its
// result leaves once the output takes it.
// Timeline state updates as a beat moves into the result register, so the next
// beat always sees it. Reset clears the state and counters, nominal_duration
// returns to 333333. A stalled output holds its beat; the input register takes a beat
// while it is empty or moving on, so input ready falls only with both registers full
// and the output blocked.
`default_nettype none
module frame_timestamp_normalizer import fts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic [TS_W-1:0]   window_limit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              accepted_o,
  output logic [MT_W-1:0]   media_time_o,
  output logic [MT_W-1:0]   duration_o,
  output logic [CNT_W-1:0]  submitted_total_o,
  output logic [CNT_W-1:0]  dropped_total_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic             s1_valid_q, s1_valid_d;
  item_t            s1_item_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  state_t           state_q, state_d;
  result_t          step_res;
  logic [NOM_W-1:0] nominal_q, nominal_d;
  logic             advance;
  logic             in_fire;
  logic             cfg_wr;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  fts_step u_step (
    .item_i    (s1_item_q),
    .state_i   (state_q),
    .nominal_i (nominal_q),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  // APB register port
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign nominal_d = (cfg_wr && paddr[2] == REG_NOMINAL) ? pwdata[NOM_W-1:0] : nominal_q;
  assign prdata    = (paddr[2] == REG_NOMINAL) ? DATA_W'(nominal_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      nominal_q   <= NOMINAL_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      nominal_q   <= nominal_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{op: op_i, timestamp: timestamp_i, window_limit: window_limit_i};
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_q.accepted;
  assign media_time_o      = out_q.media_time;
  assign duration_o        = out_q.duration;
  assign submitted_total_o = out_q.submitted_total;
  assign dropped_total_o   = out_q.dropped_total;

  // no anchor means an empty timeline
  a_no_anchor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.anchor_valid |-> (state_q.last_media_time == '0 && state_q.last_ts == '0))
    else $error("timeline not empty without anchor");

  // cached capture time tracks anchor plus last media time
  a_last_ts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.anchor_valid |->
      ({1'b0, state_q.last_ts} == {1'b0, state_q.anchor_time} + {1'b0, state_q.last_media_time}))
    else $error("last_ts out of step with anchor and media time");

  // a refused beat carries zero time fields
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.accepted) |-> (out_q.media_time == '0 && out_q.duration == '0))
    else $error("refused beat with non-zero time");

  // held input beat and state stay put while the result register is blocked
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q) && $stable(state_q)))
    else $error("input register or state changed during stall");

  // ready only drops when the input register is occupied and the output is blocked
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule
`default_nettype wire
